>>> hw/rtl/mssd_pkg.sv
// Shared types, codes and the glyph table of the three-digit display driver.
// No dependencies.
package mssd_pkg;

	localparam int ValueWidth = 10;
	localparam int MaskWidth  = 3;
	localparam int CodeWidth  = 5;
	localparam int SegWidth   = 8;
	localparam int NumDigits  = 3;
	localparam int IndexWidth = 2;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SCAN   = 1'b1;

	localparam logic [CodeWidth-1:0]  BLANK_CODE  = 5'd20;
	localparam logic [SegWidth-1:0]   BLANK_GLYPH = 8'hFD;
	localparam logic [SegWidth-1:0]   DOT_CLEAR   = 8'hFD;
	localparam logic [SegWidth-1:0]   DOT_DARK    = 8'h02;
	localparam logic [ValueWidth-1:0] MAX_VALUE   = 10'd999;

	localparam logic [SegWidth-1:0] GLYPHS [10] = '{
		8'h0A, 8'h7B, 8'h26, 8'h62, 8'h53, 8'hC2, 8'h82, 8'h6B, 8'h02, 8'h42
	};

	typedef logic [CodeWidth-1:0] code_t;

	typedef struct packed {
		code_t hund;
		code_t tens;
		code_t units;
	} digit_codes_t;

	typedef struct packed {
		logic [SegWidth-1:0]   segments_n;
		logic [NumDigits-1:0]  digit_enable_n;
		logic [IndexWidth-1:0] digit_index;
	} result_t;

	function automatic logic [SegWidth-1:0] glyph_of(input code_t code);
		logic [SegWidth-1:0] g;
		g = BLANK_GLYPH;
		if (code < 5'd10) begin
			g = GLYPHS[code[3:0]];
		end
		return g;
	endfunction

	// Saturate, split into decimal digits by parallel threshold compares,
	// then blank leading zeros.
	function automatic digit_codes_t split_value(input logic [ValueWidth-1:0] value);
		logic [ValueWidth-1:0] v;
		logic [3:0] h;
		logic [3:0] t;
		logic [6:0] r;
		logic [3:0] u;
		digit_codes_t d;
		v = (value > MAX_VALUE) ? MAX_VALUE : value;
		h = 4'd0;
		r = v[6:0];
		for (int k = 1; k < 10; k++) begin
			if (v >= 10'(k * 100)) begin
				h = 4'(k);
				r = 7'(v - 10'(k * 100));
			end
		end
		t = 4'd0;
		u = r[3:0];
		for (int k = 1; k < 10; k++) begin
			if (r >= 7'(k * 10)) begin
				t = 4'(k);
				u = 4'(r - 7'(k * 10));
			end
		end
		d.units = {1'b0, u};
		d.tens  = {1'b0, t};
		d.hund  = {1'b0, h};
		if (h == 4'd0) begin
			d.hund = BLANK_CODE;
			if (t == 4'd0) begin
				d.tens = BLANK_CODE;
			end
		end
		return d;
	endfunction

endpackage

>>> hw/rtl/mssd_in_if.sv
// Input channel of the display driver: update or scan-tick beats.
// Depends on mssd_pkg.
interface mssd_in_if;
	logic                              valid;
	logic                              ready;
	logic                              cmd;
	logic [mssd_pkg::ValueWidth-1:0]   value;
	logic [mssd_pkg::MaskWidth-1:0]    point_mask;

	modport source (output valid, output cmd, output value, output point_mask, input ready);
	modport sink   (input valid, input cmd, input value, input point_mask, output ready);
endinterface

>>> hw/rtl/mssd_out_if.sv
// Output channel of the display driver: one beat per scan tick.
// Depends on mssd_pkg.
interface mssd_out_if;
	logic                              valid;
	logic                              ready;
	logic [mssd_pkg::SegWidth-1:0]     segments_n;
	logic [mssd_pkg::NumDigits-1:0]    digit_enable_n;
	logic [mssd_pkg::IndexWidth-1:0]   digit_index;

	modport source (output valid, output segments_n, output digit_enable_n,
		output digit_index, input ready);
	modport sink   (input valid, input segments_n, input digit_enable_n,
		input digit_index, output ready);
endinterface

>>> hw/rtl/mux_seven_segment_display.sv
// Three-digit multiplexed seven-segment display driver, top level.
// Depends on mssd_pkg, mssd_in_if, mssd_out_if.
//
//  channel  dir  beat contents                         notes
//  item     in   cmd, value[9:0], point_mask[2:0]      cmd 0 update, 1 scan tick
//  result   out  segments_n[7:0], digit_enable_n[2:0], one beat per scan tick
//                digit_index[1:0]
//
// One item per cycle while item.ready is high; scan results are registered.
// Updates write the digit registers directly and give no result.
// Results sit in a two-entry buffer (output register plus skid register);
// item.ready drops only while the skid register is full.
// Reset clears the digits to "000", the dot mask and the scan position.
module mux_seven_segment_display (
	input  logic       clk,
	input  logic       arst_n,
	mssd_in_if.sink    item,
	mssd_out_if.source result
);

	mssd_pkg::code_t                  digit_codes_q [mssd_pkg::NumDigits];
	logic [mssd_pkg::MaskWidth-1:0]   dot_mask_q;
	logic [mssd_pkg::IndexWidth-1:0]  scan_pos_q;

	mssd_pkg::digit_codes_t split;
	mssd_pkg::result_t      next_res;
	mssd_pkg::result_t      main_q;
	mssd_pkg::result_t      skid_q;
	logic                   main_vld_q;
	logic                   skid_vld_q;

	logic [mssd_pkg::IndexWidth-1:0]  pos;
	logic [mssd_pkg::SegWidth-1:0]    seg;
	logic                             beat;
	logic                             upd_acc;
	logic                             scan_acc;
	logic                             main_free;

	assign item.ready = !skid_vld_q;
	assign beat       = item.valid && item.ready;
	assign upd_acc    = beat && (item.cmd == mssd_pkg::CMD_UPDATE);
	assign scan_acc   = beat && (item.cmd == mssd_pkg::CMD_SCAN);
	assign main_free  = !main_vld_q || result.ready;

	assign split = mssd_pkg::split_value(item.value);

	always_comb begin
		// position 3 cannot occur; treat it as 0
		pos = (scan_pos_q == 2'd3) ? 2'd0 : scan_pos_q;
		seg = mssd_pkg::glyph_of(digit_codes_q[pos]) & mssd_pkg::DOT_CLEAR;
		if (!dot_mask_q[pos]) begin
			seg = seg | mssd_pkg::DOT_DARK;
		end
		next_res.segments_n     = seg;
		next_res.digit_enable_n = ~(3'b001 << pos);
		next_res.digit_index    = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mssd_pkg::NumDigits; i++) begin
				digit_codes_q[i] <= '0;
			end
			dot_mask_q <= '0;
			scan_pos_q <= '0;
		end else begin
			if (upd_acc) begin
				digit_codes_q[0] <= split.units;
				digit_codes_q[1] <= split.tens;
				digit_codes_q[2] <= split.hund;
				dot_mask_q       <= item.point_mask;
			end
			if (scan_acc) begin
				scan_pos_q <= (pos == 2'd2) ? 2'd0 : pos + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (main_free) begin
				if (skid_vld_q) begin
					main_vld_q <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					main_vld_q <= scan_acc;
				end
			end else if (scan_acc) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (scan_acc) begin
				main_q <= next_res;
			end
		end else if (scan_acc) begin
			skid_q <= next_res;
		end
	end

	assign result.valid          = main_vld_q;
	assign result.segments_n     = main_q.segments_n;
	assign result.digit_enable_n = main_q.digit_enable_n;
	assign result.digit_index    = main_q.digit_index;

endmodule

>>> hw/rtl/mssd_checker.sv
// Port-level checks for the display driver, bound to the top level.
// Depends on mssd_pkg and mux_seven_segment_display.
module mssd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              in_cmd,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [mssd_pkg::SegWidth-1:0]     segments_n,
	input logic [mssd_pkg::NumDigits-1:0]    digit_enable_n,
	input logic [mssd_pkg::IndexWidth-1:0]   digit_index
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments_n)
		&& $stable(digit_enable_n) && $stable(digit_index))
		else $error("result beat changed while stalled");

	// exactly one digit driven, and it is the one named by the index
	a_enable_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(~digit_enable_n)
		&& digit_enable_n == ~(3'b001 << digit_index))
		else $error("digit enable does not match digit index");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_index != 2'd3)
		else $error("digit index out of range");

	// after a scan tick beat, a result is always valid in the next cycle
	a_scan_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == mssd_pkg::CMD_SCAN |=> out_valid)
		else $error("scan tick gave no result");

endmodule

bind mux_seven_segment_display mssd_checker u_mssd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item.valid),
	.in_ready       (item.ready),
	.in_cmd         (item.cmd),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.segments_n     (result.segments_n),
	.digit_enable_n (result.digit_enable_n),
	.digit_index    (result.digit_index)
);
